>>> design/sha_pkg.sv
// shared constants, tables and round functions for the sha-256 hasher
package sha_pkg;

   localparam int WordWidth  = 32;
   localparam int CountWidth = 61;
   localparam int RoundCount = 64;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic init_chain;
      logic start_block;
      logic round_step;
      logic fold_chain;
   } dp_cmd_type;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   localparam word_type RoundConsts [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

>>> design/sha_datapath.sv
// message schedule window that also collects block bytes, round logic and chaining state
module sha_datapath import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   input  logic       byte_we,
   input  logic [5:0] byte_addr,
   input  logic [7:0] byte_data,
   input  logic [5:0] round_idx,
   input  logic [2:0] out_idx,
   output word_type   out_word
);
   word_type   sched_ff [16];
   word_type   round_ff [8];
   word_type   chain_ff [8];
   word_type   w_cur, w_new, t1, t2, s0, s1, big0, big1, choose, major;
   logic [3:0] ri;

   assign ri = round_idx[3:0];

   always_comb begin
      s1 = rotr(sched_ff[4'(ri - 4'd2)], 17) ^ rotr(sched_ff[4'(ri - 4'd2)], 19)
           ^ (sched_ff[4'(ri - 4'd2)] >> 10);
      s0 = rotr(sched_ff[4'(ri - 4'd15)], 7) ^ rotr(sched_ff[4'(ri - 4'd15)], 18)
           ^ (sched_ff[4'(ri - 4'd15)] >> 3);
      w_new = s1 + sched_ff[4'(ri - 4'd7)] + s0 + sched_ff[ri];
      w_cur = (round_idx < 6'd16) ? sched_ff[ri] : w_new;
      big1 = rotr(round_ff[4], 6) ^ rotr(round_ff[4], 11) ^ rotr(round_ff[4], 25);
      choose = (round_ff[4] & round_ff[5]) ^ (~round_ff[4] & round_ff[6]);
      t1 = round_ff[7] + big1 + choose + RoundConsts[round_idx] + w_cur;
      big0 = rotr(round_ff[0], 2) ^ rotr(round_ff[0], 13) ^ rotr(round_ff[0], 22);
      major = (round_ff[0] & round_ff[1]) ^ (round_ff[0] & round_ff[2])
              ^ (round_ff[1] & round_ff[2]);
      t2 = big0 + major;
   end

   // bytes land big-endian in the schedule words; every byte of a block is
   // written after the previous compression and before the next one starts
   always_ff @(posedge clock) begin
      if (cmd.round_step) begin
         sched_ff[ri] <= w_cur;
      end else if (byte_we) begin
         sched_ff[byte_addr[5:2]][{~byte_addr[1:0], 3'b000} +: 8] <= byte_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) round_ff[i] <= chain_ff[i];
      end else if (cmd.round_step) begin
         for (int i = 1; i < 8; i++)
            if (i != 4) round_ff[i] <= round_ff[i-1];
         round_ff[4] <= round_ff[3] + t1;
         round_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init_chain) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_hash(3'(i));
      end else if (cmd.fold_chain) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + round_ff[i];
      end
   end

   assign out_word = chain_ff[out_idx];
endmodule

>>> design/sha_control.sv
// sequencer for byte intake, padding, rounds and digest output
module sha_control import sha_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       msg_byte,
   input  logic             has_byte,
   input  logic             end_of_message,
   output dp_cmd_type       cmd,
   output logic             byte_we,
   output logic [5:0]       byte_addr,
   output logic [7:0]       byte_data,
   output logic [5:0]       round_idx,
   output logic [2:0]       out_idx,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_last
);
   typedef enum logic [2:0] {
      S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [5:0]            round_ff, round_in;
   logic [5:0]            pad_ff, pad_in;
   logic [2:0]            out_ff, out_in;
   logic                  final_ff, final_in;
   logic                  ending_ff, ending_in;
   logic [CountWidth+2:0] bits;
   logic                  accept;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign bits = {count_ff, 3'b000};
   assign round_idx = round_ff;
   assign out_idx = out_ff;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_last = (out_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      pad_in = pad_ff;
      out_in = out_ff;
      final_in = final_ff;
      ending_in = ending_ff;
      cmd = '0;
      byte_we = 1'b0;
      byte_addr = count_ff[5:0];
      byte_data = msg_byte;
      case (state_ff)
         S_IDLE: if (accept) begin
            ending_in = end_of_message;
            final_in = 1'b0;
            if (has_byte) begin
               byte_we = 1'b1;
               count_in = count_ff + 1'b1;
               if (count_ff[5:0] == 6'd63) state_in = S_START;
               else if (end_of_message) state_in = S_PAD;
            end else if (end_of_message) state_in = S_PAD;
            pad_in = count_in[5:0];
         end
         S_PAD: begin
            byte_we = 1'b1;
            byte_addr = pad_ff;
            pad_in = pad_ff + 1'b1;
            if (pad_ff == count_ff[5:0] && !final_ff) byte_data = 8'h80;
            else if (pad_ff >= 6'd56 && final_ff)
               byte_data = bits[8*(7-(pad_ff-6'd56)) +: 8];
            else byte_data = 8'h00;
            if (pad_ff == 6'd63) state_in = S_START;
            else if (pad_ff == 6'd55 && pad_ff >= count_ff[5:0] && !final_ff) begin
               final_in = 1'b1;
            end
            if (pad_ff == count_ff[5:0] && !final_ff && pad_ff < 6'd56 &&
                pad_ff != 6'd55) final_in = 1'b1;
            if (pad_ff == 6'd55 && !final_ff && count_ff[5:0] <= 6'd55)
               final_in = 1'b1;
         end
         S_START: begin
            cmd.start_block = 1'b1;
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold_chain = 1'b1;
            out_in = '0;
            if (!ending_ff) state_in = S_IDLE;
            else if (final_ff) state_in = S_OUT;
            else begin
               // a message that ends on a block boundary still needs its 0x80 marker
               final_in = (count_ff[5:0] != 6'd0);
               pad_in = 6'd0;
               state_in = S_PAD;
            end
         end
         S_OUT: if (rsp_tready) begin
            out_in = out_ff + 1'b1;
            if (out_ff == 3'd7) begin
               cmd.init_chain = 1'b1;
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         final_ff <= 1'b0;
         ending_ff <= 1'b0;
         out_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         final_ff <= final_in;
         ending_ff <= ending_in;
         out_ff <= out_in;
      end
      round_ff <= round_in;
      pad_ff <= pad_in;
   end
endmodule

>>> design/sha256_hasher_unit.sv
// sha-256 hasher top level: byte stream in, digest words out
// a byte is taken while idle; after the last byte of a block, the block runs through the start, round and fold states
// end of message: padding writes the pad bytes into the block, each pad block is then compressed,
// then eight digest beats follow, one per cycle when rsp_tready is high
// bytes are not taken while a block runs its rounds, one round per cycle
// synchronous reset loads the initial hash values and clears the byte count
module sha256_hasher_unit import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // msg_byte
   input  logic        req_tuser,  // has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word, word_index, zero fill
   output logic        rsp_tlast
);
   dp_cmd_type cmd;
   logic       byte_we;
   logic [5:0] byte_addr, round_idx;
   logic [7:0] byte_data;
   logic [2:0] out_idx;
   word_type   out_word;

   sha_control u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .msg_byte(req_tdata), .has_byte(req_tuser), .end_of_message(req_tlast),
      .cmd, .byte_we, .byte_addr, .byte_data, .round_idx, .out_idx,
      .rsp_tvalid, .rsp_tready, .rsp_last(rsp_tlast)
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd, .byte_we, .byte_addr, .byte_data,
      .round_idx, .out_idx, .out_word
   );

   assign rsp_tdata = {5'b0, out_idx, out_word};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input ready while output busy");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[34:32] == 3'd7) else $error("bad last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
endmodule

>>> tb/sv/tb_sha256_hasher_unit.sv
// self-checking testbench for the sha-256 hasher: byte stream in, predicted digest words checked
module tb_sha256_hasher_unit;
   import sha_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       has_byte;
      logic       eom;
      bit         drain;
   } msg_beat_type;

   typedef struct {
      word_type   word;
      logic [2:0] idx;
      logic       last;
   } digest_beat_type;

   localparam word_type IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam int WatchdogLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // msg_byte
   logic        req_tuser = 1'b0; // has_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word, word_index, zero fill
   logic        rsp_tlast;

   sha256_hasher_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   msg_beat_type    pending_beats[$];
   digest_beat_type digest_expect[$];
   word_type        chain[8];
   logic [7:0]      blk[64];
   logic [60:0]     nbytes;
   int              errors = 0;
   int              idle_cycles = 0;

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_blk();
      word_type w[16];
      word_type v[8];
      word_type s0, s1, t1, t2, wi;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wi = w[i];
         end else begin
            s1 = ror(w[(i-2)%16], 17) ^ ror(w[(i-2)%16], 19) ^ (w[(i-2)%16] >> 10);
            s0 = ror(w[(i-15)%16], 7) ^ ror(w[(i-15)%16], 18) ^ (w[(i-15)%16] >> 3);
            wi = s1 + w[(i-7)%16] + s0 + w[i%16];
            w[i%16] = wi;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConsts[i] + wi;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic absorb_beat(msg_beat_type b);
      int         pos;
      logic [63:0] bits;
      digest_beat_type d;
      if (b.has_byte) begin
         pos = int'(nbytes[5:0]);
         blk[pos] = b.data;
         nbytes = nbytes + 61'd1;
         if (pos == 63) compress_blk();
      end
      if (b.eom) begin
         pos = int'(nbytes[5:0]);
         bits = {nbytes, 3'b000};
         blk[pos] = 8'h80;
         pos++;
         if (pos > 56) begin
            while (pos < 64) blk[pos++] = 8'h00;
            compress_blk();
            pos = 0;
         end
         while (pos < 56) blk[pos++] = 8'h00;
         for (int i = 0; i < 8; i++) blk[56+i] = bits[8*(7-i) +: 8];
         compress_blk();
         for (int i = 0; i < 8; i++) begin
            d.word = chain[i];
            d.idx  = 3'(i);
            d.last = (i == 7);
            digest_expect.push_back(d);
         end
         chain  = IV;
         nbytes = '0;
      end
   endtask

   // sender: bursts with gaps, optional drain hold
   int burst_left = 8;
   int gap_left = 0;
   always @(posedge clock) begin
      msg_beat_type b;
      logic         nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         chain  = IV;
         nbytes = '0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            b.data = req_tdata;
            b.has_byte = req_tuser;
            b.eom = req_tlast;
            absorb_beat(b);
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && digest_expect.size() > 0)) begin
               b = pending_beats.pop_front();
               req_tdata <= b.data;
               req_tuser <= b.has_byte;
               req_tlast <= b.eom;
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // receiver stall pattern, in random modes: always ready, random ready or periodic ready
   int stall_cyc = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      stall_cyc++;
      if (stall_cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_cyc % 4 == 0);
      endcase
   end

   // result check and watchdog
   always @(posedge clock) begin
      digest_beat_type d;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_expect.size() == 0) begin
            $error("unexpected digest beat %h", rsp_tdata);
            errors++;
         end else begin
            d = digest_expect.pop_front();
            if (rsp_tdata[31:0] !== d.word) begin
               $error("digest_word expected %h actual %h", d.word, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[34:32] !== d.idx) begin
               $error("word_index expected %0d actual %0d", d.idx, rsp_tdata[34:32]);
               errors++;
            end
            if (rsp_tlast !== d.last) begin
               $error("last_word expected %0b actual %0b", d.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic add_beat(logic [7:0] data, logic hb, logic eom, bit drain = 0);
      msg_beat_type b;
      b.data = data; b.has_byte = hb; b.eom = eom; b.drain = drain;
      pending_beats.push_back(b);
   endtask

   task automatic add_message(int len, bit eom_on_byte, bit drain);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) add_beat(8'($urandom), 1'b0, 1'b0);
         add_beat(8'($urandom), 1'b1, eom_on_byte && i == len - 1, drain && i == 0);
      end
      if (!eom_on_byte || len == 0) add_beat(8'($urandom), 1'b0, 1'b1, drain && len == 0);
   endtask

   initial begin
      int total;
      int len;
      int odd_lens[9];
      odd_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
      // directed: empty, single bytes at extremes, idle beats, end with byte
      add_beat(8'h00, 1'b0, 1'b1);
      add_beat(8'hff, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b1);
      add_beat(8'hff, 1'b1, 1'b1);
      add_beat(8'h61, 1'b1, 1'b0);
      add_beat(8'h62, 1'b1, 1'b0);
      add_beat(8'h63, 1'b1, 1'b0);
      add_beat(8'h00, 1'b0, 1'b0);
      add_beat(8'h5a, 1'b0, 1'b1);
      add_beat(8'hff, 1'b1, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0);
      add_beat(8'ha5, 1'b1, 1'b1, 1);
      total = 12;
      while (total < 370) begin
         len = ($urandom_range(0, 2) == 0) ? odd_lens[$urandom_range(0, 8)]
                                           : $urandom_range(0, 20);
         if (len > 370 - total) len = 370 - total;
         add_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
         total += len + 1;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_beats.size() == 0 && !req_tvalid && digest_expect.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && digest_expect.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
design/sha_pkg.sv
design/sha_datapath.sv
design/sha_control.sv
design/sha256_hasher_unit.sv
tb/sv/tb_sha256_hasher_unit.sv
